// ===== rtl/mo9_pkg.sv =====
// ----------------------------------------------------------------------------
// mo9_pkg
// Shared types, constants and the median-of-nine network table for the
// per-channel median filter.
// ----------------------------------------------------------------------------
package mo9_pkg;

  localparam int MAX_CHANNELS = 16;
  localparam int SAMPLE_BITS  = 12;
  localparam int TAPS         = 9;
  localparam int STORE_DEPTH  = MAX_CHANNELS * TAPS;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);
  localparam int CNT_W        = $clog2(MAX_CHANNELS + 1);
  localparam int CHAN_W       = 4;
  localparam int TAP_IDX_W    = $clog2(TAPS);
  localparam int NET_STEPS    = 19;
  localparam int STEP_W       = $clog2(NET_STEPS);
  localparam int LIMIT_W      = ADDR_W + 1;

  // Register map of the configuration port.
  localparam int PADDR_W      = 3;
  localparam int PDATA_W      = 32;
  localparam logic REG_CHANNELS_IN_USE = 1'b0;
  localparam int CFG_REG_W    = 5;
  localparam logic [CFG_REG_W-1:0] CHANNELS_RESET = CFG_REG_W'(16);

  localparam logic MODE_STORE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SORT,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic [TAP_IDX_W-1:0] lo;
    logic [TAP_IDX_W-1:0] hi;
  } pair_t;

  // Control from the sequencer to the compare-and-swap unit.
  typedef struct packed {
    logic                 load;
    logic [TAP_IDX_W-1:0] load_idx;
    logic                 step;
    logic [STEP_W-1:0]    step_idx;
  } cas_ctrl_t;

  // The 19 compare-and-swap steps of the median-of-nine network.
  function automatic pair_t net_pair(input logic [STEP_W-1:0] k);
    pair_t p;
    p = '0;
    case (k)
      5'd0:    p = '{lo: 4'd1, hi: 4'd2};
      5'd1:    p = '{lo: 4'd4, hi: 4'd5};
      5'd2:    p = '{lo: 4'd7, hi: 4'd8};
      5'd3:    p = '{lo: 4'd0, hi: 4'd1};
      5'd4:    p = '{lo: 4'd3, hi: 4'd4};
      5'd5:    p = '{lo: 4'd6, hi: 4'd7};
      5'd6:    p = '{lo: 4'd1, hi: 4'd2};
      5'd7:    p = '{lo: 4'd4, hi: 4'd5};
      5'd8:    p = '{lo: 4'd7, hi: 4'd8};
      5'd9:    p = '{lo: 4'd0, hi: 4'd3};
      5'd10:   p = '{lo: 4'd5, hi: 4'd8};
      5'd11:   p = '{lo: 4'd4, hi: 4'd7};
      5'd12:   p = '{lo: 4'd3, hi: 4'd6};
      5'd13:   p = '{lo: 4'd1, hi: 4'd4};
      5'd14:   p = '{lo: 4'd2, hi: 4'd5};
      5'd15:   p = '{lo: 4'd4, hi: 4'd7};
      5'd16:   p = '{lo: 4'd4, hi: 4'd2};
      5'd17:   p = '{lo: 4'd6, hi: 4'd4};
      5'd18:   p = '{lo: 4'd4, hi: 4'd2};
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/mo9_ram.sv =====
// ----------------------------------------------------------------------------
// mo9_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
module mo9_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 144
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/mo9_cfg.sv =====
// ----------------------------------------------------------------------------
// mo9_cfg
// Configuration register behind the APB-style port. Holds the channel count
// as written and supplies the clamped count and the buffer wrap length.
// ----------------------------------------------------------------------------
module mo9_cfg
  import mo9_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready,
  output logic [CNT_W-1:0]    count,
  output logic [LIMIT_W-1:0]  limit
);

  logic [CFG_REG_W-1:0] channels_r;
  logic [CFG_REG_W-1:0] channels_nxt;
  logic                 wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_CHANNELS_IN_USE);

  always_comb begin
    channels_nxt = channels_r;
    if (wr_en) begin
      channels_nxt = pwdata[CFG_REG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channels_r <= CHANNELS_RESET;
    end else begin
      channels_r <= channels_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_CHANNELS_IN_USE) begin
      prdata = PDATA_W'(channels_r);
    end
  end

  // The register keeps what was written; zero acts as one channel and
  // anything above the maximum acts as the maximum.
  always_comb begin
    if (channels_r == '0) begin
      count = CNT_W'(1);
    end else if (channels_r > CFG_REG_W'(MAX_CHANNELS)) begin
      count = CNT_W'(MAX_CHANNELS);
    end else begin
      count = channels_r[CNT_W-1:0];
    end
  end

  assign limit = (LIMIT_W'(count) << 3) + LIMIT_W'(count);

endmodule

// ===== rtl/mo9_cas.sv =====
// ----------------------------------------------------------------------------
// mo9_cas
// Nine tap registers and the single compare-and-swap unit that steps through
// the median-of-nine network one pair per cycle.
// ----------------------------------------------------------------------------
module mo9_cas
  import mo9_pkg::*;
(
  input  logic                   clk,
  input  cas_ctrl_t              ctrl,
  input  logic [SAMPLE_BITS-1:0] load_data,
  output logic [SAMPLE_BITS-1:0] median
);

  logic [SAMPLE_BITS-1:0] taps_r   [TAPS];
  logic [SAMPLE_BITS-1:0] taps_nxt [TAPS];
  pair_t                  pair;
  logic [SAMPLE_BITS-1:0] val_lo;
  logic [SAMPLE_BITS-1:0] val_hi;
  logic                   swap;

  assign pair   = net_pair(ctrl.step_idx);
  assign val_lo = taps_r[pair.lo];
  assign val_hi = taps_r[pair.hi];
  assign swap   = val_lo > val_hi;

  always_comb begin
    for (int i = 0; i < TAPS; i++) begin
      taps_nxt[i] = taps_r[i];
      if (ctrl.load && (ctrl.load_idx == TAP_IDX_W'(i))) begin
        taps_nxt[i] = load_data;
      end else if (ctrl.step && swap) begin
        if (pair.lo == TAP_IDX_W'(i)) begin
          taps_nxt[i] = val_hi;
        end else if (pair.hi == TAP_IDX_W'(i)) begin
          taps_nxt[i] = val_lo;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < TAPS; i++) begin
      taps_r[i] <= taps_nxt[i];
    end
  end

  assign median = taps_r[4];

endmodule

// ===== rtl/adc_channel_median_of_nine.sv =====
// ----------------------------------------------------------------------------
// adc_channel_median_of_nine
// Per-channel median-of-nine filter over an interleaved sample store.
// ----------------------------------------------------------------------------
// A store word (mode 0) writes its sample at the write position and
// produces no result; the position wraps at nine times the channel count.
// A query word (mode 1) for a valid channel goes from acceptance to the
// result register by reading the channel's nine samples at a stride of
// the channel count through the single read port of the sample RAM, then
// the nineteen compare-and-swap steps of the median network on one shared
// comparator, and then loading the result. A query for a channel at or
// beyond the count in use goes straight to the final state and gives
// bad_channel set and a median of zero. While a query is in progress
// in_stall is high; store words are taken while a result still waits on the
// output. The store reads as zero after reset through a valid flag per
// entry, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module adc_channel_median_of_nine
  import mo9_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_mode,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic [CHAN_W-1:0]      in_channel,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [SAMPLE_BITS-1:0] out_median,
  output logic                   out_bad_channel,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_W-1:0]     paddr,
  input  logic [PDATA_W-1:0]     pwdata,
  output logic [PDATA_W-1:0]     prdata,
  output logic                   pready
);

  seq_state_t state_r, state_nxt;

  logic [CNT_W-1:0]       count;
  logic [LIMIT_W-1:0]     limit;
  logic                   in_accept;
  logic                   store_go;
  logic                   query_go;
  logic                   chan_bad;

  logic [ADDR_W-1:0]      wpos_r, wpos_nxt;
  logic [ADDR_W-1:0]      wr_addr;
  logic [LIMIT_W-1:0]     wr_next;
  logic                   store_vld_r [STORE_DEPTH];

  logic [ADDR_W-1:0]      rd_addr_r, rd_addr_nxt;
  logic [TAP_IDX_W-1:0]   rd_cnt_r, rd_cnt_nxt;
  logic                   cap_vld_r, cap_vld_nxt;
  logic [TAP_IDX_W-1:0]   cap_idx_r, cap_idx_nxt;
  logic                   hit_r, hit_nxt;
  logic [STEP_W-1:0]      step_r, step_nxt;
  logic                   bad_r, bad_nxt;
  logic                   issue;

  logic [SAMPLE_BITS-1:0] ram_q;
  logic [SAMPLE_BITS-1:0] tap_data;
  logic [SAMPLE_BITS-1:0] median;
  cas_ctrl_t              cas_ctrl;

  logic                   out_valid_r, out_valid_nxt;
  logic [SAMPLE_BITS-1:0] out_median_r, out_median_nxt;
  logic                   out_bad_r, out_bad_nxt;
  logic                   out_load;

  mo9_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .count   (count),
    .limit   (limit)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign store_go  = in_accept && (in_mode == MODE_STORE);
  assign query_go  = in_accept && (in_mode == MODE_QUERY);
  assign chan_bad  = {1'b0, in_channel} >= count;

  // Write position: a position left beyond the wrap length by a lowered
  // count restarts at zero.
  assign wr_addr = (LIMIT_W'(wpos_r) >= limit) ? '0 : wpos_r;
  assign wr_next = LIMIT_W'(wr_addr) + LIMIT_W'(1);

  always_comb begin
    wpos_nxt = wpos_r;
    if (store_go) begin
      wpos_nxt = (wr_next >= limit) ? '0 : wr_next[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wpos_r <= '0;
      for (int i = 0; i < STORE_DEPTH; i++) begin
        store_vld_r[i] <= 1'b0;
      end
    end else begin
      wpos_r <= wpos_nxt;
      if (store_go) begin
        store_vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  mo9_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (store_go),
    .waddr (wr_addr),
    .wdata (in_sample),
    .raddr (rd_addr_r),
    .rdata (ram_q)
  );

  assign tap_data = hit_r ? ram_q : '0;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (query_go) begin
          state_nxt = chan_bad ? S_DONE : S_READ;
        end
      end
      S_READ: begin
        if (rd_cnt_r == TAP_IDX_W'(TAPS)) begin
          state_nxt = S_SORT;
        end
      end
      S_SORT: begin
        if (step_r == STEP_W'(NET_STEPS - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs and counters.
  always_comb begin
    rd_addr_nxt = rd_addr_r;
    rd_cnt_nxt  = rd_cnt_r;
    cap_vld_nxt = 1'b0;
    cap_idx_nxt = cap_idx_r;
    hit_nxt     = hit_r;
    step_nxt    = step_r;
    bad_nxt     = bad_r;
    issue       = 1'b0;
    case (state_r)
      S_IDLE: begin
        rd_addr_nxt = ADDR_W'(in_channel);
        rd_cnt_nxt  = '0;
        step_nxt    = '0;
        if (query_go) begin
          bad_nxt = chan_bad;
        end
      end
      S_READ: begin
        issue = rd_cnt_r != TAP_IDX_W'(TAPS);
        if (issue) begin
          cap_vld_nxt = 1'b1;
          cap_idx_nxt = rd_cnt_r;
          hit_nxt     = store_vld_r[rd_addr_r];
          rd_cnt_nxt  = rd_cnt_r + TAP_IDX_W'(1);
          rd_addr_nxt = rd_addr_r + ADDR_W'(count);
        end
      end
      S_SORT: begin
        step_nxt = step_r + STEP_W'(1);
      end
      S_DONE: begin
        step_nxt = step_r;
      end
      default: begin
        step_nxt = '0;
      end
    endcase
  end

  assign cas_ctrl.load     = cap_vld_r;
  assign cas_ctrl.load_idx = cap_idx_r;
  assign cas_ctrl.step     = (state_r == S_SORT);
  assign cas_ctrl.step_idx = step_r;

  mo9_cas u_cas (
    .clk       (clk),
    .ctrl      (cas_ctrl),
    .load_data (tap_data),
    .median    (median)
  );

  // Output register.
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt  = out_valid_r && out_stall;
    out_median_nxt = out_median_r;
    out_bad_nxt    = out_bad_r;
    if (out_load) begin
      out_valid_nxt  = 1'b1;
      out_median_nxt = bad_r ? '0 : median;
      out_bad_nxt    = bad_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
      rd_cnt_r    <= '0;
      step_r      <= '0;
      bad_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cap_vld_r   <= cap_vld_nxt;
      out_valid_r <= out_valid_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      step_r      <= step_nxt;
      bad_r       <= bad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r    <= rd_addr_nxt;
    cap_idx_r    <= cap_idx_nxt;
    hit_r        <= hit_nxt;
    out_median_r <= out_median_nxt;
    out_bad_r    <= out_bad_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_median      = out_median_r;
  assign out_bad_channel = out_bad_r;

  // A result word only appears on leaving the final state of a query.
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result word raised outside the final state");

  // A flagged channel always carries a zero median.
  a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_bad_r |-> out_median_r == '0)
    else $error("bad channel result with non-zero median");

  // A query for a channel in range starts reading the store next cycle.
  a_good_query_reads: assert property (@(posedge clk) disable iff (!rst_n)
    query_go && !chan_bad |=> state_r == S_READ)
    else $error("valid query did not start the store read");

  // The network step counter never runs past the last step while sorting.
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SORT |-> step_r < STEP_W'(NET_STEPS))
    else $error("network step beyond the last pair");

  // No sample is written while a query is gathering its taps.
  a_no_store_in_query: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !store_go)
    else $error("store write during a query");

endmodule

// ===== verif/adc_channel_median_of_nine_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_channel_median_of_nine_tb
// Drives store and query words through the median filter under random gaps
// and output stalls. It keeps its own copy of the sample store, write position
// and channel count, and checks each result against the median it predicts.
// The channel count is reprogrammed between phases, with the extremes included.
// ----------------------------------------------------------------------------
module adc_channel_median_of_nine_tb;
  import mo9_pkg::*;

  typedef struct packed {
    logic                   mode;
    logic [SAMPLE_BITS-1:0] sample;
    logic [CHAN_W-1:0]      chan;
  } adc_word_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] median;
    logic                   bad;
  } median_result_t;

  // Compare-and-swap pairs of the median-of-nine network, step 0 first.
  localparam logic [0:18][3:0] CAS_LO = {4'd1, 4'd4, 4'd7, 4'd0, 4'd3, 4'd6, 4'd1,
                                         4'd4, 4'd7, 4'd0, 4'd5, 4'd4, 4'd3, 4'd1,
                                         4'd2, 4'd4, 4'd4, 4'd6, 4'd4};
  localparam logic [0:18][3:0] CAS_HI = {4'd2, 4'd5, 4'd8, 4'd1, 4'd4, 4'd7, 4'd2,
                                         4'd5, 4'd8, 4'd3, 4'd8, 4'd7, 4'd6, 4'd4,
                                         4'd5, 4'd7, 4'd2, 4'd4, 4'd2};
  localparam int unsigned HOLD_AT     = 265;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned SETTLE      = 40;
  localparam int unsigned PHASES      = 12;
  localparam int unsigned PHASE_WORDS = 160;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   in_mode = MODE_STORE;
  logic [SAMPLE_BITS-1:0] in_sample = '0;
  logic [CHAN_W-1:0]      in_channel = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [SAMPLE_BITS-1:0] out_median;
  logic                   out_bad_channel;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [PADDR_W-1:0]     paddr = '0;
  logic [PDATA_W-1:0]     pwdata = '0;
  logic [PDATA_W-1:0]     prdata;
  logic                   pready;

  adc_channel_median_of_nine dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_sample       (in_sample),
    .in_channel      (in_channel),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_median      (out_median),
    .out_bad_channel (out_bad_channel),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // Shadow of the block's state.
  logic [SAMPLE_BITS-1:0] shadow_store [STORE_DEPTH];
  logic [7:0]             shadow_wr_pos = '0;
  logic [CFG_REG_W-1:0]   shadow_channels = CHANNELS_RESET;

  adc_word_t      word_q [$];
  median_result_t pending_medians [$];

  int unsigned words_taken = 0;
  int unsigned mismatches = 0;
  int unsigned tx_gap = 0;
  int unsigned rx_wait = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  logic        calm = 1'b0;

  initial begin
    for (int i = 0; i < STORE_DEPTH; i++) shadow_store[i] = '0;
  end

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int unsigned active_channels();
    if (shadow_channels == 0) begin
      return 1;
    end
    if (shadow_channels > MAX_CHANNELS) begin
      return MAX_CHANNELS;
    end
    return 32'(shadow_channels);
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return SAMPLE_BITS'($urandom_range(0, 3));
      default: return SAMPLE_BITS'($urandom());
    endcase
  endfunction

  // Updates the shadow store for a store word, or queues the median a query
  // word should give.
  task automatic apply_word(input adc_word_t w);
    int unsigned cnt;
    int unsigned lim;
    int unsigned pos;
    int unsigned addr;
    logic [SAMPLE_BITS-1:0] tap [9];
    logic [SAMPLE_BITS-1:0] t;
    median_result_t r;
    cnt = active_channels();
    lim = cnt * TAPS;
    if (w.mode == MODE_STORE) begin
      pos = 32'(shadow_wr_pos);
      // A position left beyond the wrap by a lowered count restarts at zero.
      if (pos >= lim) pos = 0;
      shadow_store[pos] = w.sample;
      pos++;
      if (pos >= lim) pos = 0;
      shadow_wr_pos = pos[7:0];
    end else begin
      if (w.chan >= cnt) begin
        r.median = '0;
        r.bad = 1'b1;
      end else begin
        addr = 32'(w.chan);
        for (int i = 0; i < TAPS; i++) begin
          tap[i] = shadow_store[addr];
          addr += cnt;
        end
        for (int k = 0; k < 19; k++) begin
          if (tap[CAS_LO[k]] > tap[CAS_HI[k]]) begin
            t = tap[CAS_LO[k]];
            tap[CAS_LO[k]] = tap[CAS_HI[k]];
            tap[CAS_HI[k]] = t;
          end
        end
        r.median = tap[4];
        r.bad = 1'b0;
      end
      pending_medians.push_back(r);
    end
  endtask

  // Sender: one word per handshake, with a random gap after each outside the calm phases.
  always @(posedge clk) begin : sender
    int unsigned gap;
    logic take;
    adc_word_t w;
    take = 1'b0;
    if (in_valid && !in_stall) begin
      apply_word('{mode: in_mode, sample: in_sample, chan: in_channel});
      words_taken <= words_taken + 1;
      gap = calm ? 0 : $urandom_range(0, 6);
      if (gap == 0) begin
        take = 1'b1;
      end else begin
        tx_gap <= gap;
      end
    end else if (!in_valid) begin
      if (tx_gap != 0) begin
        tx_gap <= tx_gap - 1;
      end else begin
        take = 1'b1;
      end
    end
    if (take) begin
      if (word_q.size() != 0) begin
        w = word_q.pop_front();
        in_mode    <= w.mode;
        in_sample  <= w.sample;
        in_channel <= w.chan;
        in_valid   <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end else if (in_valid && !in_stall) begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: random stall after each result outside the calm phases, plus one long
  // hold-off part way through so that a result backs up and the input stalls behind it.
  always @(posedge clk) begin : receiver
    int unsigned nxt_hold;
    int unsigned nxt_wait;
    nxt_hold = hold_left;
    nxt_wait = rx_wait;
    if (!hold_done && words_taken == HOLD_AT) begin
      nxt_hold = HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (nxt_hold != 0) begin
      nxt_hold--;
    end
    if (out_valid && !out_stall) begin
      nxt_wait = calm ? 0 : $urandom_range(0, 6);
    end else if (nxt_wait != 0) begin
      nxt_wait--;
    end
    hold_left <= nxt_hold;
    rx_wait   <= nxt_wait;
    out_stall <= (nxt_hold != 0) || (nxt_wait != 0);
  end

  always @(posedge clk) begin : result_check
    median_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_medians.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: median %0d bad_channel %0b",
                   out_median, out_bad_channel);
        end
      end else begin
        exp_r = pending_medians.pop_front();
        if (out_median !== exp_r.median || out_bad_channel !== exp_r.bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: median %0d bad_channel %0b, expected %0d %0b",
                     out_median, out_bad_channel, exp_r.median, exp_r.bad);
          end
        end
      end
    end
  end

  task automatic push_word(input logic m, input logic [SAMPLE_BITS-1:0] s,
                           input logic [CHAN_W-1:0] c);
    word_q.push_back('{mode: m, sample: s, chan: c});
  endtask

  // Waits until every word is taken and every result has come, then lets a
  // store word still in flight settle.
  task automatic drain();
    do @(negedge clk);
    while (word_q.size() != 0 || in_valid || pending_medians.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_channels(input logic [CFG_REG_W-1:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * REG_CHANNELS_IN_USE);
    // Bits above the register are junk that the block must drop.
    pwdata  <= ($urandom() & ~32'h1F) | PDATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    shadow_channels = v;
    @(negedge clk);
  endtask

  // Mostly whole scan laps of random samples followed by a few queries, with
  // some words of pure noise mixed in.
  task automatic fill_phase(input int unsigned n);
    int unsigned made;
    int unsigned cnt;
    int unsigned laps;
    int unsigned nq;
    logic [CHAN_W-1:0] c;
    made = 0;
    cnt = active_channels();
    while (made < n) begin
      if ($urandom_range(0, 4) != 0) begin
        laps = $urandom_range(1, 2);
        for (int i = 0; i < laps * cnt; i++) begin
          push_word(MODE_STORE, pick_sample(), CHAN_W'($urandom()));
          made++;
        end
        nq = $urandom_range(1, 4);
        for (int i = 0; i < nq; i++) begin
          if ($urandom_range(0, 7) != 0) c = CHAN_W'($urandom_range(0, cnt - 1));
          else c = CHAN_W'($urandom());
          push_word(MODE_QUERY, SAMPLE_BITS'($urandom()), c);
          made++;
        end
      end else begin
        push_word($urandom_range(0, 1) ? MODE_QUERY : MODE_STORE, pick_sample(),
                  CHAN_W'($urandom()));
        made++;
      end
    end
  endtask

  logic [CFG_REG_W-1:0] phase_channels [PHASES] =
    '{5'd16, 5'd1, 5'd5, 5'd31, 5'd2, 5'd16, 5'd0, 5'd9, 5'd17, 5'd3, 5'd12, 5'd16};

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // A freshly reset store reads as zero.
    push_word(MODE_QUERY, '1, 4'd0);
    push_word(MODE_QUERY, '0, 4'd15);
    push_word(MODE_STORE, 12'hFFF, 4'd15);
    push_word(MODE_STORE, 12'h000, 4'd0);
    push_word(MODE_STORE, 12'h800, 4'd0);
    push_word(MODE_STORE, 12'h7FF, 4'd0);
    push_word(MODE_STORE, 12'h001, 4'd0);
    push_word(MODE_STORE, 12'hFFE, 4'd0);
    push_word(MODE_STORE, 12'h555, 4'd0);
    push_word(MODE_STORE, 12'hAAA, 4'd0);
    push_word(MODE_STORE, 12'h123, 4'd0);
    push_word(MODE_STORE, 12'hFFF, 4'd0);
    push_word(MODE_STORE, 12'h000, 4'd0);
    push_word(MODE_STORE, 12'h800, 4'd0);
    drain();

    // One channel: the write position is now past the wrap and restarts.
    write_channels(5'd1);
    push_word(MODE_STORE, 12'hFFF, 4'd0);
    push_word(MODE_STORE, 12'hFFF, 4'd0);
    push_word(MODE_STORE, 12'hFFF, 4'd0);
    push_word(MODE_QUERY, '0, 4'd0);
    push_word(MODE_QUERY, '0, 4'd1);
    push_word(MODE_QUERY, '1, 4'd15);
    drain();

    // A count of zero behaves as one.
    write_channels(5'd0);
    push_word(MODE_QUERY, '0, 4'd0);
    push_word(MODE_QUERY, '0, 4'd1);
    drain();

    // Counts above the maximum behave as the maximum.
    write_channels(5'd31);
    push_word(MODE_QUERY, '0, 4'd15);
    push_word(MODE_QUERY, '0, 4'd0);
    drain();
    write_channels(5'd17);
    push_word(MODE_QUERY, '0, 4'd15);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      write_channels(phase_channels[p]);
      calm = (p % 4 == 3);
      fill_phase(PHASE_WORDS);
      drain();
    end

    if (mismatches == 0 && pending_medians.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
